[rtl/absgs_pkg.sv]
// A/B snapshot generation selector: shared request and result types, outcome
// codes and the serial-number compare used by the scan and report logic.
// No dependencies.
`timescale 1ns / 1ps

package absgs_pkg;

  localparam int GEN_W  = 32;
  localparam int ID_W   = 64;
  localparam int CSUM_W = 32;
  localparam int REC_W  = 10;
  localparam int SLOT_W = 2;
  localparam int CNT_W  = 3;

  // Outcome codes
  localparam logic [1:0] OUTCOME_SELECTED = 2'd0;
  localparam logic [1:0] OUTCOME_NONE     = 2'd1;
  localparam logic [1:0] OUTCOME_DISAGREE = 2'd2;

  // Valid-slot counter saturation value
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic              partition_sel;
    logic [SLOT_W-1:0] slot_number;
    logic              slot_ok;
    logic [GEN_W-1:0]  generation;
    logic [ID_W-1:0]   database_id;
    logic [CSUM_W-1:0] content_checksum;
    logic [REC_W-1:0]  rec_count;
    logic              last_slot;
  } absgs_in_t;

  typedef struct packed {
    logic [1:0]        outcome;
    logic              chosen_partition;
    logic [SLOT_W-1:0] chosen_slot;
    logic [GEN_W-1:0]  chosen_generation;
    logic [CNT_W-1:0]  valid_count_a;
    logic [CNT_W-1:0]  valid_count_b;
    logic [GEN_W-1:0]  newest_gen_a;
    logic [GEN_W-1:0]  newest_gen_b;
    logic              commit_part;
    logic [SLOT_W-1:0] commit_slot;
    logic [GEN_W-1:0]  next_generation;
  } absgs_out_t;

  // Scan state after the current request, as seen by the report logic
  typedef struct packed {
    logic              found_any;
    logic              disagree;
    logic [GEN_W-1:0]  best_gen;
    logic              best_part;
    logic [SLOT_W-1:0] best_slot;
    logic [CNT_W-1:0]  cnt_a;
    logic [CNT_W-1:0]  cnt_b;
    logic [GEN_W-1:0]  ngen_a;
    logic [GEN_W-1:0]  ngen_b;
    logic [SLOT_W-1:0] nslot_a;
    logic [SLOT_W-1:0] nslot_b;
  } absgs_scan_t;

  // Serial-number compare: cand is newer when (cand - cur) mod 2^32 is in
  // 1 .. 2^31-1; exactly half range counts as not newer.
  function automatic logic is_newer(input logic [GEN_W-1:0] cand,
                                    input logic [GEN_W-1:0] cur);
    logic [GEN_W-1:0] d;
    begin
      d = cand - cur;
      is_newer = (d != '0) && !d[GEN_W-1];
    end
  endfunction

endpackage

[rtl/absgs_scan.sv]
// A/B snapshot generation selector: scan state registers and their update
// for one slot request per cycle while upd_en is high. Depends on absgs_pkg.
`timescale 1ns / 1ps

module absgs_scan #(
  parameter int SLOTS_PER_PARTITION = 4,
  parameter int MAX_RECORDS         = 768
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    upd_en,
  input  absgs_pkg::absgs_in_t    item,
  output absgs_pkg::absgs_scan_t  scan_nxt
);
  import absgs_pkg::*;

  localparam logic [4:0]  SLOTS_LIM = 5'(SLOTS_PER_PARTITION);
  localparam logic [15:0] REC_LIM   = 16'(MAX_RECORDS);

  logic              found_any_r, found_any_nxt;
  logic              disagree_r, disagree_nxt;
  logic [GEN_W-1:0]  best_gen_r, best_gen_nxt;
  logic [ID_W-1:0]   best_id_r, best_id_nxt;
  logic [CSUM_W-1:0] best_csum_r, best_csum_nxt;
  logic [REC_W-1:0]  best_cnt_r, best_cnt_nxt;
  logic              best_part_r, best_part_nxt;
  logic [SLOT_W-1:0] best_slot_r, best_slot_nxt;
  logic [CNT_W-1:0]  cnt_r [2];
  logic [CNT_W-1:0]  cnt_nxt [2];
  logic [GEN_W-1:0]  ngen_r [2];
  logic [GEN_W-1:0]  ngen_nxt [2];
  logic [SLOT_W-1:0] nslot_r [2];
  logic [SLOT_W-1:0] nslot_nxt [2];

  logic slot_good;
  logic first_here;
  logic take_best;
  logic p;

  // Screen the request: failed checks, out-of-range slot or record count
  assign slot_good = item.slot_ok
                  && ({3'b000, item.slot_number} < SLOTS_LIM)
                  && ({6'b000000, item.rec_count} <= REC_LIM);
  assign p          = item.partition_sel;
  assign first_here = (cnt_r[p] == '0);
  assign take_best  = !found_any_r || is_newer(item.generation, best_gen_r);

  // Update per-partition and overall newest tracking
  always_comb begin
    found_any_nxt = found_any_r;
    disagree_nxt  = disagree_r;
    best_gen_nxt  = best_gen_r;
    best_id_nxt   = best_id_r;
    best_csum_nxt = best_csum_r;
    best_cnt_nxt  = best_cnt_r;
    best_part_nxt = best_part_r;
    best_slot_nxt = best_slot_r;
    cnt_nxt       = cnt_r;
    ngen_nxt      = ngen_r;
    nslot_nxt     = nslot_r;
    if (slot_good) begin
      if (cnt_r[p] != CNT_MAX) begin
        cnt_nxt[p] = cnt_r[p] + 1'b1;
      end
      if (first_here || is_newer(item.generation, ngen_r[p])) begin
        ngen_nxt[p]  = item.generation;
        nslot_nxt[p] = item.slot_number;
      end
      if (take_best) begin
        found_any_nxt = 1'b1;
        best_gen_nxt  = item.generation;
        best_id_nxt   = item.database_id;
        best_csum_nxt = item.content_checksum;
        best_cnt_nxt  = item.rec_count;
        best_part_nxt = p;
        best_slot_nxt = item.slot_number;
        disagree_nxt  = 1'b0;
      end else if (item.generation == best_gen_r &&
                   (item.database_id != best_id_r ||
                    item.content_checksum != best_csum_r ||
                    item.rec_count != best_cnt_r)) begin
        disagree_nxt = 1'b1;
      end
    end
  end

  // Hand the updated state to the report logic
  always_comb begin
    scan_nxt.found_any = found_any_nxt;
    scan_nxt.disagree  = disagree_nxt;
    scan_nxt.best_gen  = best_gen_nxt;
    scan_nxt.best_part = best_part_nxt;
    scan_nxt.best_slot = best_slot_nxt;
    scan_nxt.cnt_a     = cnt_nxt[0];
    scan_nxt.cnt_b     = cnt_nxt[1];
    scan_nxt.ngen_a    = ngen_nxt[0];
    scan_nxt.ngen_b    = ngen_nxt[1];
    scan_nxt.nslot_a   = nslot_nxt[0];
    scan_nxt.nslot_b   = nslot_nxt[1];
  end

  // Advance state; clear it after the last slot of a scan
  always_ff @(posedge clk) begin
    if (!rst_n || (upd_en && item.last_slot)) begin
      found_any_r <= 1'b0;
      disagree_r  <= 1'b0;
      best_gen_r  <= '0;
      best_id_r   <= '0;
      best_csum_r <= '0;
      best_cnt_r  <= '0;
      best_part_r <= 1'b0;
      best_slot_r <= '0;
      for (int i = 0; i < 2; i++) begin
        cnt_r[i]   <= '0;
        ngen_r[i]  <= '0;
        nslot_r[i] <= '0;
      end
    end else if (upd_en) begin
      found_any_r <= found_any_nxt;
      disagree_r  <= disagree_nxt;
      best_gen_r  <= best_gen_nxt;
      best_id_r   <= best_id_nxt;
      best_csum_r <= best_csum_nxt;
      best_cnt_r  <= best_cnt_nxt;
      best_part_r <= best_part_nxt;
      best_slot_r <= best_slot_nxt;
      cnt_r       <= cnt_nxt;
      ngen_r      <= ngen_nxt;
      nslot_r     <= nslot_nxt;
    end
  end

endmodule

[rtl/absgs_report.sv]
// A/B snapshot generation selector: builds the scan result and holds it in
// the output register until the receiver takes it. Depends on absgs_pkg.
`timescale 1ns / 1ps

module absgs_report #(
  parameter int SLOTS_PER_PARTITION = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  absgs_pkg::absgs_scan_t  scan,
  input  logic                    out_ready,
  output logic                    out_valid,
  output absgs_pkg::absgs_out_t   out_data,
  output logic                    free
);
  import absgs_pkg::*;

  localparam logic [4:0] SLOTS_LIM = 5'(SLOTS_PER_PARTITION);

  logic              out_valid_r;
  absgs_out_t        out_data_r, out_data_nxt;
  logic              tp;
  logic [CNT_W-1:0]  tp_cnt;
  logic [SLOT_W-1:0] tp_nslot;
  logic [4:0]        slot_inc;
  logic [4:0]        slot_wrap;
  logic [GEN_W-1:0]  gen_inc;

  // Target partition and the slot after its newest, wrapped once
  assign tp        = ~scan.best_part;
  assign tp_cnt    = tp ? scan.cnt_b : scan.cnt_a;
  assign tp_nslot  = tp ? scan.nslot_b : scan.nslot_a;
  assign slot_inc  = {3'b000, tp_nslot} + 5'd1;
  assign slot_wrap = (slot_inc >= SLOTS_LIM) ? (slot_inc - SLOTS_LIM) : slot_inc;
  assign gen_inc   = scan.best_gen + 1'b1;

  // Format the result
  always_comb begin
    out_data_nxt = '0;
    if (!scan.found_any) begin
      out_data_nxt.outcome = OUTCOME_NONE;
    end else begin
      out_data_nxt.outcome           = scan.disagree ? OUTCOME_DISAGREE
                                                     : OUTCOME_SELECTED;
      out_data_nxt.chosen_partition  = scan.best_part;
      out_data_nxt.chosen_slot       = scan.best_slot;
      out_data_nxt.chosen_generation = scan.best_gen;
      out_data_nxt.valid_count_a     = scan.cnt_a;
      out_data_nxt.valid_count_b     = scan.cnt_b;
      out_data_nxt.newest_gen_a      = scan.ngen_a;
      out_data_nxt.newest_gen_b      = scan.ngen_b;
      if (!scan.disagree) begin
        out_data_nxt.commit_part     = tp;
        out_data_nxt.commit_slot     = (tp_cnt != '0) ? slot_wrap[SLOT_W-1:0] : '0;
        out_data_nxt.next_generation = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
      end
    end
  end

  assign free      = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

[rtl/ab_snapshot_generation_selector.sv]
// A/B snapshot generation selector top level: input register, scan state and
// result register. Depends on absgs_pkg, absgs_scan and absgs_report.
//
// Usage:
//   in_valid/in_ready/in_data carry one slot header summary per request.
//   out_valid/out_ready/out_data carry one scan result, produced only for a
//   request whose last_slot bit is set.
//   Throughput: one request per cycle unless a last request is stalled. A request
//   is held in the input register, where its scan update is applied; a last
//   request then loads the output register, which raises out_valid.
//   Stall: while a result waits in the output register, non-last requests keep
//   flowing through the scan; a last request waits in the input register until
//   the output register is free, and in_ready stays low only for that case.
//   Reset (rst_n low at a clock edge) clears both registers' valid flags and
//   all scan state; after each result the scan state is cleared as well.
//   The critical path is the 32-bit serial compare and update selection
//   between the input register and the scan/output registers.
`timescale 1ns / 1ps

module ab_snapshot_generation_selector #(
  parameter int SLOTS_PER_PARTITION = 4,
  parameter int MAX_RECORDS         = 768
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  absgs_pkg::absgs_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output absgs_pkg::absgs_out_t  out_data
);
  import absgs_pkg::*;

  logic        s1_valid_r;
  absgs_in_t   s1_data_r;
  logic        s1_fire;
  logic        out_free;
  absgs_scan_t scan_nxt;

  // Advance the held request unless it is a last one facing a full output
  assign s1_fire  = s1_valid_r && (!s1_data_r.last_slot || out_free);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  absgs_scan #(
    .SLOTS_PER_PARTITION (SLOTS_PER_PARTITION),
    .MAX_RECORDS         (MAX_RECORDS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en   (s1_fire),
    .item     (s1_data_r),
    .scan_nxt (scan_nxt)
  );

  absgs_report #(
    .SLOTS_PER_PARTITION (SLOTS_PER_PARTITION)
  ) u_report (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_fire && s1_data_r.last_slot),
    .scan      (scan_nxt),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .free      (out_free)
  );

endmodule
